// ----- sv/css_pkg.sv -----
// Types, codes and mode rule shared by the control source selector.
`timescale 1ns / 1ps
`default_nettype none

package css_pkg;

  localparam logic [2:0] SRC_UNKNOWN = 3'd0;
  localparam logic [2:0] SRC_RC      = 3'd1;

  localparam logic signed [3:0] INST_NONE = -4'sd1;

  localparam logic [3:0] MODE_RC_ONLY      = 4'd0;
  localparam logic [3:0] MODE_MAV_ONLY     = 4'd1;
  localparam logic [3:0] MODE_FALLBACK     = 4'd2;
  localparam logic [3:0] MODE_KEEP_FIRST   = 4'd3;
  localparam logic [3:0] MODE_DISABLED     = 4'd4;
  localparam logic [3:0] MODE_RC_MAV_ASC   = 4'd5;
  localparam logic [3:0] MODE_MAV_ASC_RC   = 4'd6;
  localparam logic [3:0] MODE_RC_MAV_DESC  = 4'd7;
  localparam logic [3:0] MODE_MAV_DESC_RC  = 4'd8;

  localparam logic CFG_IDX_MODE    = 1'b0;
  localparam logic CFG_IDX_TIMEOUT = 1'b1;

  localparam logic [3:0]  MODE_RESET    = MODE_KEEP_FIRST;
  localparam logic [31:0] TIMEOUT_RESET = 32'd500000;

  typedef struct packed {
    logic        command;
    logic [63:0] now_us;
    logic [2:0]  sample_source;
    logic [2:0]  sample_instance;
    logic        sample_valid;
    logic [63:0] sample_time_us;
    logic [63:0] sample_payload;
  } in_word_t;

  typedef struct packed {
    logic               chosen_valid;
    logic [2:0]         chosen_source;
    logic signed [3:0]  chosen_instance;
    logic [63:0]        chosen_stamp_us;
    logic [63:0]        chosen_sample_time_us;
    logic [63:0]        chosen_payload;
    logic               accepted;
  } out_word_t;

  typedef struct packed {
    logic               valid;
    logic [2:0]         source;
    logic signed [3:0]  instance_id;
    logic [63:0]        stamp;
    logic [63:0]        sample_time;
    logic [63:0]        payload;
  } held_t;

  function automatic logic is_rc(input logic [2:0] s);
    return s == SRC_RC;
  endfunction

  function automatic logic is_mav(input logic [2:0] s);
    return s >= 3'd2;
  endfunction

  function automatic logic mode_match(input logic [3:0] mode, input logic [2:0] src,
                                      input logic hv, input logic [2:0] hs,
                                      input logic [2:0] first_src);
    logic m;
    m = 1'b0;
    unique case (mode)
      MODE_RC_ONLY:     m = is_rc(src);
      MODE_MAV_ONLY:    m = is_mav(src) && (src == hs || !hv);
      MODE_FALLBACK:    m = (src == hs) || !hv;
      MODE_KEEP_FIRST:  m = (src == first_src) || (first_src == SRC_UNKNOWN);
      MODE_RC_MAV_ASC:  m = !hv || (src <= hs);
      MODE_MAV_ASC_RC:  m = !hv || (is_rc(src) && is_rc(hs)) ||
                            (is_mav(src) && (is_rc(hs) || src <= hs));
      MODE_RC_MAV_DESC: m = !hv || is_rc(src) || (is_mav(src) && is_mav(hs) && src >= hs);
      MODE_MAV_DESC_RC: m = !hv || (src >= hs);
      default:          m = 1'b0;
    endcase
    return m;
  endfunction

  function automatic logic is_fresh(input logic [63:0] t, input logic [31:0] timeout,
                                    input logic [63:0] now);
    logic [64:0] deadline;
    deadline = {1'b0, t} + {33'b0, timeout};
    return {1'b0, now} < deadline;
  endfunction

endpackage

`default_nettype wire

// ----- sv/css_eval.sv -----
// Revalidation and acceptance of one word against the held setpoint.
`timescale 1ns / 1ps
`default_nettype none

module css_eval
  import css_pkg::*;
#(
  parameter int NUM_INSTANCES = 8
) (
  input  logic [3:0]  mode,
  input  logic [31:0] timeout_us,
  input  in_word_t    item,
  input  held_t       held,
  input  logic [2:0]  first_source,
  output held_t       held_nxt,
  output logic [2:0]  first_source_nxt,
  output logic        accepted
);

  localparam logic [3:0] InstLimit = 4'(NUM_INSTANCES);

  logic  keep_held;
  held_t held_kept;
  logic  sample_ok;

  always_comb begin
    keep_held = held.valid && is_fresh(held.sample_time, timeout_us, item.now_us) &&
                mode_match(mode, held.source, held.valid, held.source, first_source);
    held_kept = held;
    if (!keep_held) begin
      held_kept.valid       = 1'b0;
      held_kept.instance_id = INST_NONE;
    end

    sample_ok = !item.command && ({1'b0, item.sample_instance} < InstLimit) &&
                item.sample_valid &&
                is_fresh(item.sample_time_us, timeout_us, item.now_us) &&
                mode_match(mode, item.sample_source, held_kept.valid, held_kept.source,
                           first_source);

    held_nxt         = held_kept;
    first_source_nxt = first_source;
    if (sample_ok) begin
      held_nxt.valid       = 1'b1;
      held_nxt.source      = item.sample_source;
      held_nxt.instance_id = $signed({1'b0, item.sample_instance});
      held_nxt.stamp       = item.now_us;
      held_nxt.sample_time = item.sample_time_us;
      held_nxt.payload     = item.sample_payload;
      if (first_source == SRC_UNKNOWN) begin
        first_source_nxt = item.sample_source;
      end
    end
    accepted = sample_ok;
  end

endmodule

`default_nettype wire

// ----- sv/control_source_selector_unit.sv -----
// Top level of the control source selector: input register, evaluation, held setpoint.
// One word per cycle unless the result side stalls, one result word per input word.
// A word is registered on entry in the input register; when the result register is free
// or being taken, the revalidation of the held setpoint and the acceptance test (two
// 65-bit deadline compares and the mode rule) update the held setpoint, which together
// with the accepted flag forms the result register. While a result waits, an empty input
// register still takes one more word, after which the input stalls. Full rate holds as
// long as the result side keeps taking words.
`timescale 1ns / 1ps
`default_nettype none

module control_source_selector_unit
  import css_pkg::*;
#(
  parameter int NUM_INSTANCES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  logic        in_valid_r;
  in_word_t    in_word_r;
  logic        out_valid_r;
  logic        acc_r;
  held_t       held_r;
  logic [2:0]  first_src_r;
  logic [3:0]  mode_r;
  logic [31:0] timeout_r;

  held_t       held_nxt;
  logic [2:0]  first_src_nxt;
  logic        acc_nxt;
  logic        advance;

  css_eval #(
    .NUM_INSTANCES(NUM_INSTANCES)
  ) u_eval (
    .mode            (mode_r),
    .timeout_us      (timeout_r),
    .item            (in_word_r),
    .held            (held_r),
    .first_source    (first_src_r),
    .held_nxt        (held_nxt),
    .first_source_nxt(first_src_nxt),
    .accepted        (acc_nxt)
  );

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= 1'b0;
      held_r      <= '{valid: 1'b0, source: SRC_UNKNOWN, instance_id: INST_NONE,
                       stamp: '0, sample_time: '0, payload: '0};
      first_src_r <= SRC_UNKNOWN;
      mode_r      <= MODE_RESET;
      timeout_r   <= TIMEOUT_RESET;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        acc_r       <= acc_nxt;
        held_r      <= held_nxt;
        first_src_r <= first_src_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_IDX_MODE:    mode_r    <= cfg_wdata[3:0];
          CFG_IDX_TIMEOUT: timeout_r <= cfg_wdata;
          default:         mode_r    <= mode_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_word_r <= in_data;
    end
  end

  assign out_valid = out_valid_r;
  always_comb begin
    out_data.chosen_valid          = held_r.valid;
    out_data.chosen_source         = held_r.source;
    out_data.chosen_instance       = held_r.instance_id;
    out_data.chosen_stamp_us       = held_r.stamp;
    out_data.chosen_sample_time_us = held_r.sample_time;
    out_data.chosen_payload        = held_r.payload;
    out_data.accepted              = acc_r;
  end

  a_inst_tracks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    held_r.valid != (held_r.instance_id == INST_NONE))
    else $error("held instance disagrees with held valid");

  a_accept_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && acc_r |-> held_r.valid)
    else $error("accepted word without valid held setpoint");

  a_stall_holds_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(held_r) && $stable(acc_r))
    else $error("held setpoint changed while result stalled");

  a_first_latched: assert property (@(posedge clk) disable iff (!rst_n)
    first_src_r != SRC_UNKNOWN |=> $stable(first_src_r))
    else $error("first source changed after latching");

  a_input_waits: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(in_word_r))
    else $error("input word lost while waiting");

endmodule

`default_nettype wire
